>>> rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Shared types, byte codes and the event kind enumeration.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  localparam logic [7:0] RealtimeFirst = 8'hF8;
  localparam logic [7:0] SongPosition  = 8'hF2;
  localparam logic [7:0] SongSelect    = 8'hF3;
  localparam logic [7:0] NoStatus      = 8'h00;

  localparam logic [3:0] HiNoteOff  = 4'h8;
  localparam logic [3:0] HiNoteOn   = 4'h9;
  localparam logic [3:0] HiPolyAt   = 4'hA;
  localparam logic [3:0] HiControl  = 4'hB;
  localparam logic [3:0] HiProgram  = 4'hC;
  localparam logic [3:0] HiChanAt   = 4'hD;
  localparam logic [3:0] HiPitch    = 4'hE;
  localparam logic [3:0] HiSystem   = 4'hF;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_POLY_AT  = 3'd2,
    KIND_CC       = 3'd3,
    KIND_PROGRAM  = 3'd4,
    KIND_CHAN_AT  = 3'd5,
    KIND_PITCH    = 3'd6,
    KIND_REALTIME = 3'd7
  } event_kind_e;

  typedef struct packed {
    logic [7:0] status_byte;
    logic       awaiting_last_byte;
    logic [6:0] held_first_data;
  } parse_state_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [3:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [7:0]  realtime_byte;
  } midi_event_t;

endpackage

>>> rtl/mrsp_decode.sv
// ----------------------------------------------------------------------------
// MIDI running status decoder
// Combinational next state and event for one received byte.
// ----------------------------------------------------------------------------
module mrsp_decode (
  input  logic [7:0]            midi_byte_i,
  input  mrsp_pkg::parse_state_t state_i,
  output mrsp_pkg::parse_state_t state_o,
  output logic                  event_valid_o,
  output mrsp_pkg::midi_event_t event_o
);
  import mrsp_pkg::*;

  logic [6:0] data;
  logic [3:0] hi;
  logic [3:0] chan;

  assign data = midi_byte_i[6:0];
  assign hi   = state_i.status_byte[7:4];
  assign chan = state_i.status_byte[3:0];

  always_comb begin
    state_o       = state_i;
    event_valid_o = 1'b0;
    event_o       = '{event_kind: KIND_NOTE_OFF, channel: chan,
                      data_first: state_i.held_first_data, data_second: data,
                      realtime_byte: 8'h00};
    if (midi_byte_i >= RealtimeFirst) begin
      event_valid_o = 1'b1;
      event_o       = '{event_kind: KIND_REALTIME, channel: 4'h0, data_first: 7'h00,
                        data_second: 7'h00, realtime_byte: midi_byte_i};
    end else if (midi_byte_i[7]) begin
      state_o.status_byte        = midi_byte_i;
      state_o.awaiting_last_byte = 1'b0;
    end else if (state_i.awaiting_last_byte) begin
      state_o.awaiting_last_byte = 1'b0;
      unique case (hi)
        HiNoteOff: begin
          event_valid_o    = 1'b1;
          event_o.event_kind = KIND_NOTE_OFF;
        end
        HiNoteOn: begin
          event_valid_o    = 1'b1;
          event_o.event_kind = (data == 7'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON;
        end
        HiPolyAt: begin
          event_valid_o    = 1'b1;
          event_o.event_kind = KIND_POLY_AT;
        end
        HiControl: begin
          event_valid_o    = 1'b1;
          event_o.event_kind = KIND_CC;
        end
        HiPitch: begin
          event_valid_o    = 1'b1;
          event_o.event_kind = KIND_PITCH;
        end
        default: begin
          event_valid_o = 1'b0;
        end
      endcase
    end else if (state_i.status_byte != NoStatus) begin
      unique case (hi) inside
        HiNoteOff, HiNoteOn, HiPolyAt, HiControl, HiPitch: begin
          state_o.awaiting_last_byte = 1'b1;
          state_o.held_first_data    = data;
        end
        HiProgram, HiChanAt: begin
          state_o.held_first_data = data;
          event_valid_o           = 1'b1;
          event_o.event_kind      = (hi == HiProgram) ? KIND_PROGRAM : KIND_CHAN_AT;
          event_o.data_first      = data;
          event_o.data_second     = 7'h00;
        end
        default: begin
          if (state_i.status_byte == SongPosition) begin
            state_o.awaiting_last_byte = 1'b1;
            state_o.held_first_data    = data;
          end else if (state_i.status_byte == SongSelect) begin
            state_o.held_first_data = data;
          end
          state_o.status_byte = NoStatus;
        end
      endcase
    end
  end

endmodule

>>> rtl/mrsp_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI running status output register
// Result register that holds one event until the master side takes it.
// ----------------------------------------------------------------------------
module mrsp_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mrsp_pkg::midi_event_t event_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output mrsp_pkg::midi_event_t event_o
);
  import mrsp_pkg::*;

  logic        valid_q, valid_d;
  midi_event_t event_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      event_q <= event_i;
    end
  end

  assign valid_o = valid_q;
  assign event_o = event_q;

endmodule

>>> rtl/midi_running_status_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI running status parser unit
// Receive-side MIDI 1.0 parser that turns a byte stream into channel and
// real-time events.
// ----------------------------------------------------------------------------
// Each received byte is taken into an input register and decoded from it against
// the running status; a resulting event then sits in the output register until
// taken. The block accepts one byte every cycle while the master side keeps up,
// and an event that a byte completes passes from the input register to the
// output register on its way to the master side.
// Bytes that complete no message leave nothing on the output.
module midi_running_status_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: midi_byte[7:0]
  input  logic [mrsp_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: channel[3:0], data_first[10:4], data_second[17:11],
  // realtime_byte[25:18], zero[31:26]
  output logic [mrsp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: event_kind[2:0]
  output logic [2:0]                    m_axis_tuser_o
);
  import mrsp_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  parse_state_t state_q, state_d;
  logic         event_valid;
  midi_event_t  event_next;
  midi_event_t  event_out;
  logic         out_free;
  logic         advance;

  mrsp_decode u_decode (
    .midi_byte_i   (in_byte_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .event_valid_o (event_valid),
    .event_o       (event_next)
  );

  mrsp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && event_valid),
    .event_i (event_next),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .event_o (event_out)
  );

  assign advance         = in_valid_q && (!event_valid || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  assign m_axis_tuser_o = event_out.event_kind;
  assign m_axis_tdata_o = {6'b0, event_out.realtime_byte, event_out.data_second,
                           event_out.data_first, event_out.channel};

  a_rt_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_REALTIME) |->
      (m_axis_tdata_o[17:0] == 18'h0 && m_axis_tdata_o[25:21] == 5'h1F))
    else $error("real-time event with bad fields");

  a_chan_no_rt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != KIND_REALTIME) |->
      (m_axis_tdata_o[25:18] == 8'h00))
    else $error("channel event carries a real-time byte");

  a_status_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.status_byte == NoStatus) ||
    (state_q.status_byte[7] && state_q.status_byte < RealtimeFirst))
    else $error("running status holds a data or real-time byte");

  a_await_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.awaiting_last_byte |->
      (state_q.status_byte == NoStatus ||
       state_q.status_byte[7:4] == HiNoteOff ||
       state_q.status_byte[7:4] == HiNoteOn ||
       state_q.status_byte[7:4] == HiPolyAt ||
       state_q.status_byte[7:4] == HiControl ||
       state_q.status_byte[7:4] == HiPitch))
    else $error("second data byte awaited for a one-byte status");

endmodule
